### hw/rtl/btp_pkg.sv
package btp_pkg;

  localparam int COORD_WIDTH_DEF   = 20;
  localparam int FRACTION_BITS_DEF = 16;
  localparam int TIME_WIDTH_DEF    = 32;
  localparam int DUR_WIDTH         = 32;
  localparam int MODE_WIDTH        = 2;
  localparam int IDX_WIDTH         = 3;

  typedef enum logic [IDX_WIDTH-1:0] {
    REG_POINT_A  = 3'd0,
    REG_POINT_B  = 3'd1,
    REG_POINT_C  = 3'd2,
    REG_POINT_D  = 3'd3,
    REG_DURATION = 3'd4,
    REG_MODE     = 3'd5
  } reg_idx_t;

  typedef enum logic [MODE_WIDTH-1:0] {
    MODE_LINEAR = 2'd0,
    MODE_QUAD   = 2'd1,
    MODE_CUBIC  = 2'd2,
    MODE_CUBIC3 = 2'd3
  } mode_t;

  // Pipeline control (input valid and output stall) used by the top level.
  typedef struct packed {
    logic valid;
    logic stall;
  } stage_ctl_t;

endpackage

### hw/rtl/btp_div.sv
// Pipelined restoring divider: one quotient bit per stage.
// Quotient is floor(num / den) for a num of NUM_WIDTH bits.
module btp_div #(
  parameter int NUM_WIDTH = 48,
  parameter int DEN_WIDTH = 32,
  parameter int TAG_WIDTH = 1
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 en,
  input  logic                 in_valid,
  input  logic [NUM_WIDTH-1:0] num,
  input  logic [DEN_WIDTH-1:0] den,
  input  logic [TAG_WIDTH-1:0] tag_in,
  output logic                 out_valid,
  output logic [NUM_WIDTH-1:0] quot,
  output logic [TAG_WIDTH-1:0] tag_out
);

  localparam int RW = DEN_WIDTH + 1;

  logic [NUM_WIDTH-1:0] q_s   [NUM_WIDTH+1];
  logic [NUM_WIDTH-1:0] n_s   [NUM_WIDTH+1];
  logic [RW-1:0]        r_s   [NUM_WIDTH+1];
  logic [DEN_WIDTH-1:0] d_s   [NUM_WIDTH+1];
  logic [TAG_WIDTH-1:0] t_s   [NUM_WIDTH+1];
  logic                 v_s   [NUM_WIDTH+1];

  assign q_s[0] = '0;
  assign n_s[0] = num;
  assign r_s[0] = '0;
  assign d_s[0] = den;
  assign t_s[0] = tag_in;
  assign v_s[0] = in_valid;

  for (genvar i = 0; i < NUM_WIDTH; i++) begin : g_stage
    logic [RW-1:0] shifted;
    logic [RW:0]   diff;
    logic          fits;
    assign shifted = {r_s[i][RW-2:0], n_s[i][NUM_WIDTH-1]};
    assign diff    = {1'b0, shifted} - {2'b00, d_s[i]};
    assign fits    = ~diff[RW];

    always_ff @(posedge clk) begin
      if (rst) begin
        v_s[i+1] <= 1'b0;
      end else if (en) begin
        v_s[i+1] <= v_s[i];
      end
      if (en) begin
        r_s[i+1] <= fits ? diff[RW-1:0] : shifted;
        q_s[i+1] <= {q_s[i][NUM_WIDTH-2:0], fits};
        n_s[i+1] <= {n_s[i][NUM_WIDTH-2:0], 1'b0};
        d_s[i+1] <= d_s[i];
        t_s[i+1] <= t_s[i];
      end
    end
  end

  assign out_valid = v_s[NUM_WIDTH];
  assign quot      = q_s[NUM_WIDTH];
  assign tag_out   = t_s[NUM_WIDTH];

endmodule

### hw/rtl/btp_lerp.sv
// One de Casteljau level for one pair: a + round((b - a) * u / ONE).
// Two stages: multiply, then round and add.
module btp_lerp #(
  parameter int COORD_WIDTH   = 20,
  parameter int FRACTION_BITS = 16
) (
  input  logic                          clk,
  input  logic                          en,
  input  logic signed [COORD_WIDTH-1:0] a,
  input  logic signed [COORD_WIDTH-1:0] b,
  input  logic [FRACTION_BITS:0]        u,
  output logic signed [COORD_WIDTH-1:0] r
);

  localparam int PW = COORD_WIDTH + FRACTION_BITS + 3;

  logic signed [COORD_WIDTH:0]   d;
  logic signed [PW-1:0]          prod;
  logic signed [COORD_WIDTH-1:0] a_q;
  logic signed [PW-1:0]          rnd;

  assign d = $signed({b[COORD_WIDTH-1], b}) - $signed({a[COORD_WIDTH-1], a});
  assign rnd = prod + PW'(1 << (FRACTION_BITS - 1));

  always_ff @(posedge clk) begin
    if (en) begin
      prod <= PW'(d) * $signed({1'b0, u});
      a_q  <= a;
      r    <= COORD_WIDTH'(a_q + COORD_WIDTH'(rnd >>> FRACTION_BITS));
    end
  end

endmodule

### hw/rtl/bezier_trajectory_point.sv
// Bezier trajectory point: one signed time sample in, one 3-D point out.
// Time is normalized to u = floor(t * 2^FRACTION_BITS / curve_duration),
// clamped to 0..1.0, by a pipelined restoring divider (one quotient bit per
// stage), then three de Casteljau levels of rounded linear interpolation
// run per axis, each level two stages (multiply, round/add). Throughput is
// one transaction per cycle while the output is not stalled. The pipe has
// TIME_WIDTH+FRACTION_BITS-1 divider stages plus 1 prep stage plus 6
// interpolation stages plus the output register. The whole pipe advances
// together and freezes while the output register holds an untaken result;
// in_ready = !out_valid | out_ready.
// Quadratic mode pads the control points as (a,b,c,c) so level two gives
// its result; linear mode takes level one. Both are delayed to line up
// with level three.
// Configuration must only change while the pipe is empty.
module bezier_trajectory_point #(
  parameter int COORD_WIDTH   = btp_pkg::COORD_WIDTH_DEF,
  parameter int FRACTION_BITS = btp_pkg::FRACTION_BITS_DEF,
  parameter int TIME_WIDTH    = btp_pkg::TIME_WIDTH_DEF
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              cfg_we,
  input  logic [btp_pkg::IDX_WIDTH-1:0]     cfg_index,
  input  logic [((3*COORD_WIDTH > btp_pkg::DUR_WIDTH) ?
                 3*COORD_WIDTH : btp_pkg::DUR_WIDTH)-1:0] cfg_data,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  logic signed [TIME_WIDTH-1:0]      time_now,
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic signed [COORD_WIDTH-1:0]     pos_x,
  output logic signed [COORD_WIDTH-1:0]     pos_y,
  output logic signed [COORD_WIDTH-1:0]     pos_z
);

  localparam int DW  = btp_pkg::DUR_WIDTH;
  localparam int PTW = 3 * COORD_WIDTH;
  localparam int NW  = TIME_WIDTH - 1 + FRACTION_BITS;
  localparam int UW  = FRACTION_BITS + 1;
  localparam int TW  = 2;  // tag: clamp-low, clamp-high

  logic [PTW-1:0] point_a, point_b, point_c, point_d;
  logic [DW-1:0]  curve_duration;
  logic [btp_pkg::MODE_WIDTH-1:0] curve_mode;

  always_ff @(posedge clk) begin
    if (rst) begin
      point_a <= '0;
      point_b <= '0;
      point_c <= '0;
      point_d <= '0;
      curve_duration <= DW'(1);
      curve_mode <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        btp_pkg::REG_POINT_A:  point_a <= PTW'(cfg_data);
        btp_pkg::REG_POINT_B:  point_b <= PTW'(cfg_data);
        btp_pkg::REG_POINT_C:  point_c <= PTW'(cfg_data);
        btp_pkg::REG_POINT_D:  point_d <= PTW'(cfg_data);
        btp_pkg::REG_DURATION: curve_duration <= DW'(cfg_data);
        btp_pkg::REG_MODE:     curve_mode <= cfg_data[btp_pkg::MODE_WIDTH-1:0];
        default: ;
      endcase
    end
  end

  btp_pkg::stage_ctl_t ctl;
  assign ctl.stall = out_valid & ~out_ready;
  assign ctl.valid = in_valid;
  logic en;
  assign en = ~ctl.stall;
  assign in_ready = en;

  // Effective duration (zero reads as one) and clamp flags.
  logic [DW-1:0] dur_eff;
  logic          neg, big;
  logic [TIME_WIDTH+DW-1:0] t_ext, d_ext;
  assign dur_eff = (curve_duration == '0) ? DW'(1) : curve_duration;
  assign neg   = time_now[TIME_WIDTH-1];
  assign t_ext = (TIME_WIDTH+DW)'($unsigned(time_now));
  assign d_ext = (TIME_WIDTH+DW)'(dur_eff);
  assign big   = t_ext >= d_ext;

  logic [NW-1:0] num;
  assign num = {time_now[TIME_WIDTH-2:0], {FRACTION_BITS{1'b0}}};

  logic          dv;
  logic [NW-1:0] dq;
  logic [TW-1:0] dtag;

  btp_div #(.NUM_WIDTH(NW), .DEN_WIDTH(DW), .TAG_WIDTH(TW)) u_div (
    .clk, .rst, .en,
    .in_valid (ctl.valid & en),
    .num, .den(dur_eff), .tag_in({big, neg}),
    .out_valid(dv), .quot(dq), .tag_out(dtag)
  );

  // u select
  logic [UW-1:0] u_sel;
  always_comb begin
    if (dtag[0])      u_sel = '0;
    else if (dtag[1]) u_sel = UW'(1) << FRACTION_BITS;
    else              u_sel = UW'(dq);
  end

  // Control points padded by mode: linear uses (a,b,b,b), quad (a,b,c,c).
  logic [PTW-1:0] pb, pc, pd;
  always_comb begin
    case (btp_pkg::mode_t'(curve_mode))
      btp_pkg::MODE_LINEAR: begin
        pb = point_b; pc = point_b; pd = point_b;
      end
      btp_pkg::MODE_QUAD: begin
        pb = point_b; pc = point_c; pd = point_c;
      end
      default: begin
        pb = point_b; pc = point_c; pd = point_d;
      end
    endcase
  end

  // Stage n of the interpolation holds vn and mn (and un, up to u4) for its transaction.
  logic          v0;
  logic [UW-1:0] u0, u1, u2, u3, u4;
  logic          v1, v2, v3, v4, v5, v6;
  logic [btp_pkg::MODE_WIDTH-1:0] m0, m1, m2, m3, m4, m5, m6;

  always_ff @(posedge clk) begin
    if (rst) begin
      {v0, v1, v2, v3, v4, v5, v6} <= '0;
    end else if (en) begin
      {v0, v1, v2, v3, v4, v5, v6} <= {dv, v0, v1, v2, v3, v4, v5};
    end
    if (en) begin
      u0 <= u_sel; u1 <= u0; u2 <= u1; u3 <= u2; u4 <= u3;
      m0 <= curve_mode; m1 <= m0; m2 <= m1; m3 <= m2; m4 <= m3;
      m5 <= m4; m6 <= m5;
    end
  end

  logic signed [COORD_WIDTH-1:0] res [3];

  for (genvar ax = 0; ax < 3; ax++) begin : g_axis
    logic signed [COORD_WIDTH-1:0] ca, cb, cc, cd;
    logic signed [COORD_WIDTH-1:0] l1ab, l1bc, l1cd, l2a, l2b, l3;
    logic signed [COORD_WIDTH-1:0] l1ab_q, l1ab_qq, l2a_q;
    assign ca = point_a[ax*COORD_WIDTH +: COORD_WIDTH];
    assign cb = pb[ax*COORD_WIDTH +: COORD_WIDTH];
    assign cc = pc[ax*COORD_WIDTH +: COORD_WIDTH];
    assign cd = pd[ax*COORD_WIDTH +: COORD_WIDTH];

    btp_lerp #(.COORD_WIDTH(COORD_WIDTH), .FRACTION_BITS(FRACTION_BITS)) u_ab
      (.clk, .en, .a(ca), .b(cb), .u(u0), .r(l1ab));
    btp_lerp #(.COORD_WIDTH(COORD_WIDTH), .FRACTION_BITS(FRACTION_BITS)) u_bc
      (.clk, .en, .a(cb), .b(cc), .u(u0), .r(l1bc));
    btp_lerp #(.COORD_WIDTH(COORD_WIDTH), .FRACTION_BITS(FRACTION_BITS)) u_cd
      (.clk, .en, .a(cc), .b(cd), .u(u0), .r(l1cd));
    btp_lerp #(.COORD_WIDTH(COORD_WIDTH), .FRACTION_BITS(FRACTION_BITS)) u_l2a
      (.clk, .en, .a(l1ab), .b(l1bc), .u(u2), .r(l2a));
    btp_lerp #(.COORD_WIDTH(COORD_WIDTH), .FRACTION_BITS(FRACTION_BITS)) u_l2b
      (.clk, .en, .a(l1bc), .b(l1cd), .u(u2), .r(l2b));
    btp_lerp #(.COORD_WIDTH(COORD_WIDTH), .FRACTION_BITS(FRACTION_BITS)) u_l3
      (.clk, .en, .a(l2a), .b(l2b), .u(u4), .r(l3));

    // Level one is ready at stage 2, level two at stage 4; pick the
    // linear or quadratic value at stage 4 and carry it to stage 6.
    always_ff @(posedge clk) begin
      if (en) begin
        l1ab_q  <= l1ab;
        l1ab_qq <= l1ab_q;
        l2a_q   <= (m4 == btp_pkg::MODE_LINEAR) ? l1ab_qq : l2a;
      end
    end
    logic signed [COORD_WIDTH-1:0] lin_q, sel;
    always_ff @(posedge clk) begin
      if (en) begin
        lin_q <= l2a_q;
      end
    end
    always_comb begin
      if (m6 == btp_pkg::MODE_QUAD || m6 == btp_pkg::MODE_LINEAR) sel = lin_q;
      else sel = l3;
    end
    assign res[ax] = sel;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= v6;
    end
    if (en) begin
      pos_x <= res[0];
      pos_y <= res[1];
      pos_z <= res[2];
    end
  end

endmodule
